[design/far_pkg.sv]
// Package for the fraction arithmetic block: operation codes and shared types.
// Used by the top level, front end, queue and back end of the fraction_arith_reduce design; no dependencies.
`default_nettype none
package far_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam int unsigned WideBits = 64;
  localparam int unsigned NumOutBits = 33;
  localparam int unsigned DenOutBits = 32;

  // One classified item: unreduced numerator and denominator.
  typedef struct packed {
    logic [WideBits-1:0] num;
    logic [WideBits-1:0] den;
  } frac_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } back_state_e;

endpackage
`default_nettype wire

[design/fraction_arith_reduce.sv]
// Top level of the fraction arithmetic block with GCD reduction.
// Depends on far_pkg, far_front, far_fifo and far_back.
//
//  channel | handshake      | payload
//  input   | push, full     | kind_i, num_a_i, den_a_i, num_b_i, den_b_i
//  result  | pop, empty     | num_out_o, den_out_o
//
// The front end takes an item every cycle unless a full queue holds it back, and forms
// the products, then the sum, in registered stages. The back end loads an item, runs the
// binary GCD, then divides numerator and denominator by it in turn and hands the result
// over; with both magnitudes zero it skips to the hand-over. It takes no new item until
// the result is taken, so the back end sets the rate.
// A two-entry queue lets the front end keep accepting while the back end works.
// Reset is asynchronous and clears all control state; a held result blocks the back end.
`default_nettype none
module fraction_arith_reduce #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [1:0]              kind_i,
  input  wire logic [OPERAND_BITS-1:0] num_a_i,
  input  wire logic [OPERAND_BITS-1:0] den_a_i,
  input  wire logic [OPERAND_BITS-1:0] num_b_i,
  input  wire logic [OPERAND_BITS-1:0] den_b_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [32:0]                  num_out_o,
  output logic [31:0]                  den_out_o
);
  logic in_ready, f_valid, f_ready, q_valid, q_ready, b_valid;
  far_pkg::frac_t f_data, q_data;

  assign full = !in_ready;
  assign empty = !b_valid;

  far_front #(.OperandBits(OPERAND_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(in_ready),
    .kind_i, .num_a_i, .den_a_i, .num_b_i, .den_b_i,
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_o(f_data)
  );

  far_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  far_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_i(q_data),
    .out_valid_o(b_valid), .out_ready_i(pop), .num_o(num_out_o), .den_o(den_out_o)
  );
endmodule
`default_nettype wire

[design/far_front.sv]
// Front end: accepts operands and forms the unreduced numerator and denominator.
// Depends on far_pkg. Two register stages: products, then the sum.
`default_nettype none
module far_front #(
  parameter int unsigned OperandBits = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             kind_i,
  input  wire logic [OperandBits-1:0] num_a_i,
  input  wire logic [OperandBits-1:0] den_a_i,
  input  wire logic [OperandBits-1:0] num_b_i,
  input  wire logic [OperandBits-1:0] den_b_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output far_pkg::frac_t              out_o
);
  localparam int unsigned W = far_pkg::WideBits;

  logic s1_q, s2_q;
  logic s1_adv, s2_adv;
  logic signed [2*OperandBits-1:0] p0_q, p1_q, p2_q;
  logic [1:0] kind_q;
  far_pkg::frac_t res_q;

  logic signed [OperandBits-1:0] x0, x1, y0, y1, z0, z1;

  assign s2_adv = s1_q && (!s2_q || out_ready_i);
  assign s1_adv = !s1_q || s2_adv;
  assign in_ready_o = s1_adv;
  assign out_valid_o = s2_q;
  assign out_o = res_q;

  // Select the three products each operation needs.
  always_comb begin
    unique case (far_pkg::op_e'(kind_i))
      far_pkg::OP_ADD, far_pkg::OP_SUB: begin
        x0 = num_a_i; x1 = den_b_i; y0 = num_b_i; y1 = den_a_i;
        z0 = den_a_i; z1 = den_b_i;
      end
      far_pkg::OP_MUL: begin
        x0 = num_a_i; x1 = num_b_i; y0 = '0; y1 = '0;
        z0 = den_a_i; z1 = den_b_i;
      end
      default: begin
        x0 = num_a_i; x1 = den_b_i; y0 = '0; y1 = '0;
        z0 = den_a_i; z1 = num_b_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (s1_adv) s1_q <= in_valid_i;
      if (s2_adv) s2_q <= 1'b1;
      else if (out_ready_i) s2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      p0_q <= x0 * x1;
      p1_q <= y0 * y1;
      p2_q <= z0 * z1;
      kind_q <= kind_i;
    end
    if (s2_adv) begin
      if (far_pkg::op_e'(kind_q) == far_pkg::OP_SUB)
        res_q.num <= W'(p0_q) - W'(p1_q);
      else
        res_q.num <= W'(p0_q) + W'(p1_q);
      res_q.den <= W'(p2_q);
    end
  end
endmodule
`default_nettype wire

[design/far_fifo.sv]
// Two-entry queue between the front and the back end.
// Depends on far_pkg for the item type.
`default_nettype none
module far_fifo (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_ready_o,
  input  wire far_pkg::frac_t wr_data_i,
  output logic          rd_valid_o,
  input  wire logic     rd_ready_i,
  output far_pkg::frac_t rd_data_o
);
  far_pkg::frac_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

[design/far_back.sv]
// Back end: binary GCD over the magnitudes, then two restoring divisions.
// Depends on far_pkg. One GCD or quotient step per cycle.
`default_nettype none
module far_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire far_pkg::frac_t                  in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [far_pkg::NumOutBits-1:0]       num_o,
  output logic [far_pkg::DenOutBits-1:0]       den_o
);
  localparam int unsigned W = far_pkg::WideBits;
  localparam int unsigned CW = $clog2(W + 1);

  far_pkg::back_state_e state_q, state_d;
  logic [W-1:0] n_q, d_q, a_q, b_q, g_q, rem_q, quo_q, nq_q;
  logic [CW-1:0] sh_q, cnt_q;
  logic nneg_q, dneg_q, ok_q;
  logic [W-1:0] mag_n, mag_d, bsub, nxt_rem, diff;
  logic [W:0] trial;

  assign mag_n = in_i.num[W-1] ? -in_i.num : in_i.num;
  assign mag_d = in_i.den[W-1] ? -in_i.den : in_i.den;
  assign in_ready_o = state_q == far_pkg::ST_IDLE;
  assign out_valid_o = state_q == far_pkg::ST_DONE;
  assign nxt_rem = {rem_q[W-2:0], quo_q[W-1]};
  assign trial = {1'b0, nxt_rem} - {1'b0, g_q};
  assign bsub = b_q - a_q;
  assign diff = trial[W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      far_pkg::ST_IDLE: if (in_valid_i) state_d = far_pkg::ST_GCD;
      far_pkg::ST_GCD: begin
        if (!ok_q) state_d = far_pkg::ST_DONE;
        else if (b_q == '0) state_d = far_pkg::ST_DIVN;
      end
      far_pkg::ST_DIVN: if (cnt_q == CW'(W)) state_d = far_pkg::ST_DIVD;
      far_pkg::ST_DIVD: if (cnt_q == CW'(W)) state_d = far_pkg::ST_DONE;
      far_pkg::ST_DONE: if (out_ready_i) state_d = far_pkg::ST_IDLE;
      default: state_d = far_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= far_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // Load, binary GCD (strip shared twos, halve an even value, subtract smaller from larger), then both divisions.
  always_ff @(posedge clk_i) begin
    case (state_q)
      far_pkg::ST_IDLE: if (in_valid_i) begin
        n_q <= in_i.num;
        d_q <= in_i.den;
        nneg_q <= in_i.num[W-1];
        dneg_q <= in_i.den[W-1];
        a_q <= (mag_n == '0) ? mag_d : mag_n;
        b_q <= (mag_n == '0) ? '0 : mag_d;
        ok_q <= (mag_n | mag_d) != '0;
        sh_q <= '0;
      end
      far_pkg::ST_GCD: begin
        if (b_q == '0 && ok_q) begin
          g_q <= a_q << sh_q;
          rem_q <= '0;
          quo_q <= nneg_q ? -n_q : n_q;
          cnt_q <= '0;
        end else if (b_q != '0) begin
          if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1; b_q <= b_q >> 1; sh_q <= sh_q + CW'(1);
          end else if (!a_q[0]) a_q <= a_q >> 1;
          else if (!b_q[0]) b_q <= b_q >> 1;
          else if (a_q > b_q) begin
            b_q <= a_q - b_q; a_q <= b_q;
          end else b_q <= bsub;
        end
      end
      far_pkg::ST_DIVN, far_pkg::ST_DIVD: begin
        if (cnt_q == CW'(W)) begin
          if (state_q == far_pkg::ST_DIVN) begin
            nq_q <= nneg_q ? -quo_q : quo_q;
            rem_q <= '0;
            quo_q <= dneg_q ? -d_q : d_q;
            cnt_q <= '0;
          end else begin
            n_q <= nq_q;
            d_q <= dneg_q ? -quo_q : quo_q;
          end
        end else begin
          cnt_q <= cnt_q + CW'(1);
          if (!trial[W]) begin
            rem_q <= diff;
            quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= nxt_rem;
            quo_q <= {quo_q[W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign num_o = n_q[far_pkg::NumOutBits-1:0];
  assign den_o = d_q[far_pkg::DenOutBits-1:0];
endmodule
`default_nettype wire

[design/far_checker.sv]
// Port-level checker for fraction_arith_reduce, attached with a bind.
// Depends only on the top-level ports.
`default_nettype none
module far_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [32:0] num_out_o,
  input wire logic [31:0] den_out_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(num_out_o) && $stable(den_out_o)))
    else $error("result changed while waiting");
  a_pop_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> empty)
    else $error("result shown again right after a transfer");
  a_zero_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && den_out_o == '0) |-> (num_out_o == '0 || num_out_o == 33'd1 ||
      num_out_o == '1))
    else $error("zero denominator with unreduced numerator");
endmodule

bind fraction_arith_reduce far_checker u_far_checker (.*);
`default_nettype wire

[dv/far_checker.sv]
// Checker for fraction_arith_reduce: watches both transfer channels, predicts each result.
// Depends on far_pkg for the operation codes.
module far_scoreboard (
  input  logic        clk_i,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  kind_i,
  input  logic [15:0] num_a_i,
  input  logic [15:0] den_a_i,
  input  logic [15:0] num_b_i,
  input  logic [15:0] den_b_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [32:0] num_out_o,
  input  logic [31:0] den_out_o,
  output int          errors_o,
  output int          pending_o
);
  logic [64:0] expected_q[$];

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] div_signed(logic [63:0] x, logic [63:0] g);
    logic [63:0] q;
    q = mag64(x) / g;
    return x[63] ? -q : q;
  endfunction

  // Forms the cross products at 64 bits, reduces by the GCD and truncates.
  function automatic logic [64:0] reduce_fraction(far_pkg::op_e op, logic [15:0] na16,
      logic [15:0] da16, logic [15:0] nb16, logic [15:0] db16);
    logic [63:0] na, da, nb, db, n, d, g;
    na = {{48{na16[15]}}, na16};
    da = {{48{da16[15]}}, da16};
    nb = {{48{nb16[15]}}, nb16};
    db = {{48{db16[15]}}, db16};
    case (op)
      far_pkg::OP_ADD: begin n = na * db + nb * da; d = da * db; end
      far_pkg::OP_SUB: begin n = na * db - nb * da; d = da * db; end
      far_pkg::OP_MUL: begin n = na * nb; d = da * db; end
      default: begin n = na * db; d = da * nb; end
    endcase
    g = gcd64(mag64(n), mag64(d));
    if (g != 0) begin
      n = div_signed(n, g);
      d = div_signed(d, g);
    end
    return {n[32:0], d[31:0]};
  endfunction

  initial errors_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    logic [64:0] want;
    int bad;
    bad = 0;
    if (push && !full)
      expected_q.push_back(reduce_fraction(far_pkg::op_e'(kind_i), num_a_i, den_a_i,
                                           num_b_i, den_b_i));
    if (pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: num %h den %h", $time,
                 num_out_o, den_out_o);
        bad = bad + 1;
      end else begin
        want = expected_q.pop_front();
        if (want[64:32] !== num_out_o) begin
          $display("%0t: num_out expected %h actual %h", $time, want[64:32], num_out_o);
          bad = bad + 1;
        end
        if (want[31:0] !== den_out_o) begin
          $display("%0t: den_out expected %h actual %h", $time, want[31:0], den_out_o);
          bad = bad + 1;
        end
      end
    end
    if (bad != 0) errors_o <= errors_o + bad;
  end
endmodule

[dv/tb_fraction_arith_reduce.sv]
// Testbench top for fraction_arith_reduce: drives directed and random items with idling.
// Depends on far_pkg, the design files and far_scoreboard.
module tb_fraction_arith_reduce;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [1:0]  kind_i = '0;
  logic [15:0] num_a_i = '0, den_a_i = 16'd1, num_b_i = '0, den_b_i = 16'd1;
  logic        empty;
  logic        pop = 0;
  logic [32:0] num_out_o;
  logic [31:0] den_out_o;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;

  fraction_arith_reduce #(.OPERAND_BITS(16)) i_dut (.*);

  far_scoreboard i_checker (
    .clk_i, .push, .full, .kind_i, .num_a_i, .den_a_i, .num_b_i, .den_b_i,
    .empty, .pop, .num_out_o, .den_out_o, .errors_o(errors), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  // Receiver: decides pop for the next edge at each falling edge.
  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_fraction_arith_reduce: FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(7) - 3);
      4: return 16'($urandom_range(300) - 150);
      default: return 16'($urandom);
    endcase
  endfunction

  // Holds push for one item until the transfer happens.
  task automatic send_fraction(far_pkg::op_e op, logic [15:0] na, logic [15:0] da,
                               logic [15:0] nb, logic [15:0] db);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk_i);
    end
    push <= 1;
    kind_i <= op;
    num_a_i <= na;
    den_a_i <= da;
    num_b_i <= nb;
    den_b_i <= db;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] ds;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    for (int k = 0; k < 4; k++) begin
      send_fraction(far_pkg::op_e'(k), 16'd1, 16'd2, 16'd1, 16'd3);
      send_fraction(far_pkg::op_e'(k), 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      send_fraction(far_pkg::op_e'(k), 16'h7fff, 16'hffff, 16'h8000, 16'h7fff);
    end
    send_fraction(far_pkg::OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);      // divide by zero fraction
    send_fraction(far_pkg::OP_MUL, 16'd0, 16'd0, 16'd4, 16'd9);      // both products zero
    send_fraction(far_pkg::OP_ADD, 16'd3, 16'd0, 16'hfffd, 16'd2);   // zero input denominator
    send_fraction(far_pkg::OP_SUB, 16'd2, 16'd4, 16'd1, 16'd2);      // zero numerator
    send_fraction(far_pkg::OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(far_pkg::OP_ADD, 16'hffff, 16'h0000, 16'hffff, 16'h0000);
    // Hold off until everything drained once.
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < 375; n++) begin
        ds = pick_value();
        if ($urandom_range(9) != 0 && ds == 0) ds = 16'd1;
        send_fraction(far_pkg::op_e'($urandom_range(3)), pick_value(), ds, pick_value(),
                      ($urandom_range(19) == 0) ? 16'd0 : pick_value());
      end
    end
    drain();
    repeat (400) @(negedge clk_i);
    if (errors == 0 && pending == 0) $display("tb_fraction_arith_reduce: PASS");
    else $display("tb_fraction_arith_reduce: FAIL");
    $finish;
  end
endmodule

[filelist.f]
design/far_pkg.sv
design/far_front.sv
design/far_fifo.sv
design/far_back.sv
design/fraction_arith_reduce.sv
design/far_checker.sv
dv/far_checker.sv
dv/tb_fraction_arith_reduce.sv
